// ----- design/aeps_pkg.sv -----
// ----------------------------------------------------------------------------
// aeps_pkg
// Shared types and codes of the active/expired priority scheduler: request
// and response beats, controller commands, function and status codes.
// ----------------------------------------------------------------------------
package aeps_pkg;

   // request function codes
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_PICK = 1'b1;

   // response status codes
   localparam logic [1:0] STAT_PICKED = 2'd0;
   localparam logic [1:0] STAT_ADDED  = 2'd1;
   localparam logic [1:0] STAT_NONE   = 2'd2;
   localparam logic [1:0] STAT_FULL   = 2'd3;

   // field widths
   localparam int ID_W   = 10;
   localparam int PRIO_W = 2;
   localparam int CSR_W  = 3;

   // level-count register value after reset
   localparam logic [CSR_W-1:0] MAX_PRIO_RESET = 3'd4;

   typedef struct packed {
      logic              func;
      logic [ID_W-1:0]   task_id;
      logic [PRIO_W-1:0] dyn_prio;
      logic              expired;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] picked_id;
      logic [1:0]      status;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the request beat
      logic execute;   // update queues, access entry memory
      logic load;      // move the result into the response register
   } cmd_type;

endpackage

// ----- design/aeps_ctrl.sv -----
// ----------------------------------------------------------------------------
// aeps_ctrl
// Controller of the scheduler: sequences capture, execute and result stages
// and owns both handshakes.
// ----------------------------------------------------------------------------
module aeps_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output aeps_pkg::cmd_type cmd
);
   import aeps_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   // response register can take a new beat
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !reset &&
                      ((state_ff == ST_IDLE) || ((state_ff == ST_FIN) && out_free));
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.capture = accept;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign cmd.load    = (state_ff == ST_FIN) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      priority if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // an accepted beat is executed in the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted request not executed");

   // execution always hands over to the result stage
   a_exec_fin: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> state_ff == ST_FIN)
      else $error("execute not followed by result stage");

   // a stalled response keeps the result stage waiting
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) && rsp_valid_ff && !rsp_ready |=> state_ff == ST_FIN)
      else $error("result stage left while response stalled");

   // a response only appears out of the result stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside result stage");

endmodule

// ----- design/aeps_dpath.sv -----
// ----------------------------------------------------------------------------
// aeps_dpath
// Datapath of the scheduler: level heads and counts, bank select, level
// register, task entry memory and the response register.
// ----------------------------------------------------------------------------
module aeps_dpath #(
   parameter int NUM_LEVELS  = 4,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  aeps_pkg::cmd_type             cmd,
   input  aeps_pkg::req_type             req_data,
   output aeps_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [aeps_pkg::CSR_W-1:0]    csr_wr_data
);
   import aeps_pkg::*;

   localparam int SLOTS   = 2 * NUM_LEVELS;
   localparam int ENTRIES = SLOTS * QUEUE_DEPTH;
   localparam int LVL_W   = $clog2(NUM_LEVELS);
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int M_W     = ($clog2(NUM_LEVELS + 1) > CSR_W) ?
                            $clog2(NUM_LEVELS + 1) : CSR_W;

   // registers
   req_type          req_ff;
   rsp_type          rsp_data_ff;
   logic [CSR_W-1:0] max_prio_ff;
   logic             active_bank_ff, active_bank_in;
   logic [CNT_W-1:0] counts_ff [SLOTS];
   logic [CNT_W-1:0] counts_in [SLOTS];
   logic [PTR_W-1:0] heads_ff  [SLOTS];
   logic [PTR_W-1:0] heads_in  [SLOTS];
   logic [1:0]       res_status_ff, res_status_in;
   logic             res_hit_ff, res_hit_in;
   logic [ID_W-1:0]  rdata_ff;
   logic [ID_W-1:0]  mem [ENTRIES];

   // combinational
   logic [M_W-1:0]    mp_ext, m_eff, top_prio, prio_ext, prio_clamp, lvl_full;
   logic [LVL_W-1:0]  add_lvl, pick_lvl;
   logic              add_bank, pick_bank, swap, add_full;
   logic [SLOT_W-1:0] add_slot, pick_slot;
   logic [PTR_W:0]    tail_sum;
   logic [PTR_W-1:0]  tail_pos, pick_head, pick_head_nxt;
   logic [NUM_LEVELS-1:0] ne0, ne1, ne_sel;
   logic              any0, any1, act_any, exp_any, pick_hit;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;

   // effective number of levels, clamped priority, target level
   always_comb begin
      mp_ext = M_W'(max_prio_ff);
      priority if (mp_ext == '0) begin
         m_eff = M_W'(1);
      end else if (mp_ext > M_W'(NUM_LEVELS)) begin
         m_eff = M_W'(NUM_LEVELS);
      end else begin
         m_eff = mp_ext;
      end
      top_prio   = m_eff - M_W'(1);
      prio_ext   = M_W'(req_ff.dyn_prio);
      prio_clamp = (prio_ext > top_prio) ? top_prio : prio_ext;
      lvl_full   = top_prio - prio_clamp;
      add_lvl    = lvl_full[LVL_W-1:0];
   end

   // add target slot, full check, tail position
   always_comb begin
      add_bank = active_bank_ff ^ req_ff.expired;
      add_slot = add_bank ? (SLOT_W'(NUM_LEVELS) + SLOT_W'(add_lvl)) : SLOT_W'(add_lvl);
      add_full = (counts_ff[add_slot] == CNT_W'(QUEUE_DEPTH));
      tail_sum = {1'b0, heads_ff[add_slot]} + {1'b0, counts_ff[add_slot][PTR_W-1:0]};
      if (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (PTR_W + 1)'(QUEUE_DEPTH);
      end
      tail_pos = tail_sum[PTR_W-1:0];
   end

   // occupancy flags per bank
   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         ne0[l] = (counts_ff[l] != '0);
         ne1[l] = (counts_ff[NUM_LEVELS + l] != '0);
      end
      any0    = |ne0;
      any1    = |ne1;
      act_any = active_bank_ff ? any1 : any0;
      exp_any = active_bank_ff ? any0 : any1;
      swap    = !act_any && exp_any;
   end

   // highest-priority (lowest-index) non-empty level of the bank served
   always_comb begin
      pick_bank = active_bank_ff ^ swap;
      ne_sel    = pick_bank ? ne1 : ne0;
      pick_hit  = |ne_sel;
      pick_lvl  = '0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (ne_sel[l]) pick_lvl = LVL_W'(l);
      end
      pick_slot = pick_bank ? (SLOT_W'(NUM_LEVELS) + SLOT_W'(pick_lvl))
                            : SLOT_W'(pick_lvl);
      pick_head = heads_ff[pick_slot];
      pick_head_nxt = (pick_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : pick_head + PTR_W'(1);
   end

   // queue state update and memory commands
   always_comb begin
      counts_in      = counts_ff;
      heads_in       = heads_ff;
      active_bank_in = active_bank_ff;
      res_status_in  = res_status_ff;
      res_hit_in     = res_hit_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = ADDR_W'(add_slot) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_pos);
      if (cmd.execute) begin
         res_hit_in = 1'b0;
         if (req_ff.func == FUNC_ADD) begin
            if (add_full) begin
               res_status_in = STAT_FULL;
            end else begin
               mem_we              = 1'b1;
               counts_in[add_slot] = counts_ff[add_slot] + CNT_W'(1);
               res_status_in       = STAT_ADDED;
            end
         end else begin
            active_bank_in = pick_bank;
            mem_addr = ADDR_W'(pick_slot) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pick_head);
            if (pick_hit) begin
               mem_re               = 1'b1;
               heads_in[pick_slot]  = pick_head_nxt;
               counts_in[pick_slot] = counts_ff[pick_slot] - CNT_W'(1);
               res_status_in        = STAT_PICKED;
               res_hit_in           = 1'b1;
            end else begin
               res_status_in = STAT_NONE;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_prio_ff    <= MAX_PRIO_RESET;
         active_bank_ff <= 1'b0;
         for (int s = 0; s < SLOTS; s++) begin
            counts_ff[s] <= '0;
            heads_ff[s]  <= '0;
         end
      end else begin
         if (csr_wr_en) max_prio_ff <= csr_wr_data;
         active_bank_ff <= active_bank_in;
         counts_ff      <= counts_in;
         heads_ff       <= heads_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      res_status_ff <= res_status_in;
      res_hit_ff    <= res_hit_in;
      if (cmd.load) begin
         rsp_data_ff.status    <= res_status_ff;
         rsp_data_ff.picked_id <= res_hit_ff ? rdata_ff : '0;
      end
   end

   // task entry memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= req_ff.task_id;
   end

   always_ff @(posedge clock) begin
      if (mem_re) rdata_ff <= mem[mem_addr];
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ----- design/active_expired_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// active_expired_priority_scheduler
// Two-bank multilevel priority scheduler with active and expired FIFO levels.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : request beats (add a task or pick the next one), valid/ready.
//   rsp_*  : one response beat per request, in order, valid/ready.
//   csr_*  : write-only level-count register, taken at any edge with
//            csr_wr_en high; write it only while no request is in flight.
// Timing:
//   a response becomes valid after its request has passed the execute and
//   result stages; a new request is taken while idle or in the result stage,
//   not during execute, which holds the single entry-memory access (one
//   write for an add, one registered read for a pick).
// Stall:
//   while a response waits, the next request is still accepted and executed;
//   it then waits in the result stage until the response register frees up.
// Reset:
//   all levels empty, bank 0 active, level count 4; the entry memory is not
//   cleared, and no entry is read before it has been written.
// ----------------------------------------------------------------------------
module active_expired_priority_scheduler #(
   parameter int NUM_LEVELS  = 4,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  aeps_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output aeps_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [aeps_pkg::CSR_W-1:0] csr_wr_data
);
   import aeps_pkg::*;

   cmd_type cmd;

   // sequencing and handshakes
   aeps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // queues, memory and result
   aeps_dpath #(
      .NUM_LEVELS  (NUM_LEVELS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule
